// ===== design/hdc_pkg.sv =====
// Shared types and constants for the haversine distance pipeline.
package hdc_pkg;

    localparam int CORDIC_STEPS = 24;

    localparam int AW = 34;   // CORDIC datapath width, signed Q30 with headroom

    typedef struct packed {
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] y;
        logic signed [AW-1:0] z;
    } xyz_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } sqrt_t;

    // atan(2^-i) in Q30, truncated
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

endpackage

// ===== design/haversine_distance_top.sv =====
// Haversine great-circle distance pipeline, top level.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------
//  request | req_valid | req_stall | lon_a, lat_a, lon_b, lat_b
//  result  | rsp_valid | rsp_stall | metres
//
// One request per cycle while the result is not stalled; a request passes through
// five input stages, two CORDIC cell rows, 32 square-root cells, three product
// stages and two output stages.
// Reset clears only the stage valid bits; the datapath carries no reset.
// A stalled result freezes the whole pipeline; req_stall follows it.
module haversine_distance_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic signed [28:0] lon_a,
    input  logic signed [27:0] lat_a,
    input  logic signed [28:0] lon_b,
    input  logic signed [27:0] lat_b,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [24:0]        metres
);

    localparam int NS  = hdc_pkg::CORDIC_STEPS;
    localparam int AW  = hdc_pkg::AW;
    localparam int LAT = 42 + 2 * NS;

    localparam logic signed [31:0] FULL_UDEG    = 32'sd360000000;
    localparam logic [28:0]        HALF_UDEG    = 29'd180000000;
    localparam logic [27:0]        HALF_UDEG28  = 28'd180000000;
    localparam logic [27:0]        QUART_UDEG   = 28'd90000000;
    localparam logic [63:0]        PI_Q60       = 64'h3243F6A8885A308D;
    localparam logic [34:0]        RAD_PER_UDEG = 35'(PI_Q60 / 64'd180000000);
    localparam logic [16:0]        RAD_LO       = RAD_PER_UDEG[16:0];
    localparam logic [17:0]        RAD_HI       = RAD_PER_UDEG[34:17];
    localparam logic signed [AW-1:0] GAIN_Q30   = 34'sh26DD3B6A;
    localparam logic [30:0]        ONE_Q30      = 31'h40000000;
    localparam logic [30:0]        HALF_PI_Q30  = 31'h6487ED51;
    localparam logic [23:0]        TWO_EARTH_M  = 24'd12734000;
    localparam logic [24:0]        MAX_METRES   = 25'd20002432;

    // difference reduced into 0..360 degrees
    function automatic logic [28:0] wrap_udeg(input logic signed [29:0] d);
        logic signed [31:0] dw;
        logic signed [31:0] r;
        dw = 32'(d);
        if (dw >= FULL_UDEG)
            r = dw - FULL_UDEG;
        else if (dw >= 0)
            r = dw;
        else if (dw + FULL_UDEG >= 0)
            r = dw + FULL_UDEG;
        else
            r = dw + FULL_UDEG + FULL_UDEG;
        return r[28:0];
    endfunction

    function automatic logic [30:0] clamp_q30(input logic signed [AW-1:0] v);
        if (v[AW-1])
            return 31'd0;
        else if (v > signed'({3'b000, ONE_Q30}))
            return ONE_Q30;
        else
            return v[30:0];
    endfunction

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = rsp_valid && rsp_stall;
    assign rsp_valid = vld_reg[LAT-1];
    assign vld_next  = {vld_reg[LAT-2:0], req_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    logic signed [28:0] lona_ext;
    logic signed [28:0] lonb_ext;
    logic signed [28:0] lata_ext;
    logic signed [28:0] latb_ext;
    assign lona_ext = lon_a;
    assign lonb_ext = lon_b;
    assign lata_ext = 29'(lat_a);
    assign latb_ext = 29'(lat_b);

    // stage 1: differences
    logic signed [28:0] dlat_reg;
    logic signed [29:0] dlon_reg;
    logic signed [27:0] lata_reg;
    logic signed [27:0] latb_reg;

    // stage 2: wrapped differences, latitude magnitudes
    logic [28:0] rlat_reg;
    logic [28:0] rlon_reg;
    logic [27:0] absa_reg;
    logic [27:0] absb_reg;

    // stage 3: lane angles in microdegrees; lanes: dlat, dlon, cos a, cos b
    logic [27:0] m3_reg [4];
    logic [27:0] m3_next [4];
    logic [1:0]  neg3_reg;
    logic [1:0]  neg3_next;

    // stage 4/5: radian conversion split into two partial products
    logic [44:0] plo_reg [4];
    logic [45:0] phi_reg [4];
    logic [1:0]  neg4_reg;
    logic [31:0] ang5_reg [4];
    logic [1:0]  neg5_reg;

    logic [27:0] mcos_a;
    logic [27:0] mcos_b;

    always_comb
    begin
        m3_next[0] = (rlat_reg > HALF_UDEG) ? 28'(29'(FULL_UDEG) - rlat_reg) : rlat_reg[27:0];
        m3_next[1] = (rlon_reg > HALF_UDEG) ? 28'(29'(FULL_UDEG) - rlon_reg) : rlon_reg[27:0];
        mcos_a = (absa_reg > HALF_UDEG28) ? HALF_UDEG28 : absa_reg;
        mcos_b = (absb_reg > HALF_UDEG28) ? HALF_UDEG28 : absb_reg;
        neg3_next[0] = mcos_a > QUART_UDEG;
        neg3_next[1] = mcos_b > QUART_UDEG;
        m3_next[2] = neg3_next[0] ? HALF_UDEG28 - mcos_a : mcos_a;
        m3_next[3] = neg3_next[1] ? HALF_UDEG28 - mcos_b : mcos_b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlat_reg <= 29'(latb_ext) - 29'(lata_ext);
            dlon_reg <= 30'(lonb_ext) - 30'(lona_ext);
            lata_reg <= lat_a;
            latb_reg <= lat_b;

            rlat_reg <= wrap_udeg(30'(dlat_reg));
            rlon_reg <= wrap_udeg(dlon_reg);
            absa_reg <= lata_reg[27] ? 28'(-lata_reg) : lata_reg;
            absb_reg <= latb_reg[27] ? 28'(-latb_reg) : latb_reg;

            for (int l = 0; l < 4; l++)
            begin
                m3_reg[l]  <= m3_next[l];
                plo_reg[l] <= 45'(m3_reg[l]) * 45'(RAD_LO);
                phi_reg[l] <= 46'(m3_reg[l]) * 46'(RAD_HI);
            end
            neg3_reg <= neg3_next;
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
        end
    end

    logic [62:0] full_rad [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            full_rad[l] = {phi_reg[l], 17'd0} + 63'(plo_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // half angles take one more bit of shift
            ang5_reg[0] <= full_rad[0][62:31];
            ang5_reg[1] <= full_rad[1][62:31];
            ang5_reg[2] <= full_rad[2][61:30];
            ang5_reg[3] <= full_rad[3][61:30];
        end
    end

    // sine/cosine rows
    hdc_pkg::xyz_t rot_d [4][NS+1];
    logic [1:0] neg_line_reg [NS];

    genvar gl, gi;
    generate
        for (gl = 0; gl < 4; gl++)
        begin : g_rot_lane
            assign rot_d[gl][0].x = GAIN_Q30;
            assign rot_d[gl][0].y = '0;
            assign rot_d[gl][0].z = signed'({2'b00, ang5_reg[gl]});
            for (gi = 0; gi < NS; gi++)
            begin : g_rot_cell
                hdc_rot_cell u_cell (
                    .clk   (clk),
                    .en    (en),
                    .step  (5'(gi)),
                    .d_in  (rot_d[gl][gi]),
                    .d_out (rot_d[gl][gi+1])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_line_reg[0] <= neg5_reg;
            for (int i = 1; i < NS; i++)
            begin
                neg_line_reg[i] <= neg_line_reg[i-1];
            end
        end
    end

    // products
    logic [30:0] s_lat;
    logic [30:0] s_lon;
    logic [30:0] c_a;
    logic [30:0] c_b;
    logic signed [31:0] cs_a;
    logic signed [31:0] cs_b;
    logic [61:0] sq_lat;
    logic [61:0] sq_lon;
    logic signed [63:0] cc_prod;
    logic signed [63:0] t_prod;
    logic signed [33:0] a_sum;

    logic [30:0] slat1_reg;
    logic [30:0] slon1_reg;
    logic signed [31:0] cc1_reg;
    logic [30:0] slat2_reg;
    logic signed [31:0] t2_reg;
    logic [30:0] a3_reg;

    always_comb
    begin
        s_lat   = clamp_q30(rot_d[0][NS].y);
        s_lon   = clamp_q30(rot_d[1][NS].y);
        c_a     = clamp_q30(rot_d[2][NS].x);
        c_b     = clamp_q30(rot_d[3][NS].x);
        cs_a    = neg_line_reg[NS-1][0] ? -signed'({1'b0, c_a}) : signed'({1'b0, c_a});
        cs_b    = neg_line_reg[NS-1][1] ? -signed'({1'b0, c_b}) : signed'({1'b0, c_b});
        sq_lat  = 62'(s_lat) * 62'(s_lat);
        sq_lon  = 62'(s_lon) * 62'(s_lon);
        cc_prod = 64'(cs_a) * 64'(cs_b);
        t_prod  = 64'(cc1_reg) * signed'({33'd0, slon1_reg});
        a_sum   = 34'(t2_reg) + signed'({3'b000, slat2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slat1_reg <= sq_lat[60:30];
            slon1_reg <= sq_lon[60:30];
            cc1_reg   <= cc_prod[61:30];
            slat2_reg <= slat1_reg;
            t2_reg    <= t_prod[61:30];
            a3_reg    <= clamp_q30(a_sum);
        end
    end

    // square roots of a and 1-a
    hdc_pkg::sqrt_t sq_d [2][33];
    logic [30:0] one_minus_a;

    assign one_minus_a  = ONE_Q30 - a3_reg;
    assign sq_d[0][0].n   = {3'd0, a3_reg, 30'd0};
    assign sq_d[0][0].res = '0;
    assign sq_d[1][0].n   = {3'd0, one_minus_a, 30'd0};
    assign sq_d[1][0].res = '0;

    generate
        for (gl = 0; gl < 2; gl++)
        begin : g_sqrt_lane
            for (gi = 0; gi < 32; gi++)
            begin : g_sqrt_cell
                hdc_sqrt_cell u_cell (
                    .clk   (clk),
                    .en    (en),
                    .step  (5'(gi)),
                    .d_in  (sq_d[gl][gi]),
                    .d_out (sq_d[gl][gi+1])
                );
            end
        end
    endgenerate

    // atan2 row
    hdc_pkg::xyz_t vec_d [NS+1];

    assign vec_d[0].y = signed'(sq_d[0][32].res[AW-1:0]);
    assign vec_d[0].x = signed'(sq_d[1][32].res[AW-1:0]);
    assign vec_d[0].z = '0;

    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_vec_cell
            hdc_vec_cell u_cell (
                .clk   (clk),
                .en    (en),
                .step  (5'(gi)),
                .d_in  (vec_d[gi]),
                .d_out (vec_d[gi+1])
            );
        end
    endgenerate

    // scale to metres
    logic [30:0] z_clamp;
    logic [54:0] dist_reg;
    logic [55:0] dist_round;
    logic [25:0] dist_q;
    logic [24:0] metres_reg;
    logic [24:0] metres_next;

    always_comb
    begin
        if (vec_d[NS].z[AW-1])
            z_clamp = 31'd0;
        else if (vec_d[NS].z > signed'({3'b000, HALF_PI_Q30}))
            z_clamp = HALF_PI_Q30;
        else
            z_clamp = vec_d[NS].z[30:0];
        dist_round  = 56'(dist_reg) + 56'(1 << 29);
        dist_q      = dist_round[55:30];
        metres_next = (dist_q > 26'(MAX_METRES)) ? MAX_METRES : dist_q[24:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg   <= 55'(z_clamp) * 55'(TWO_EARTH_M);
            metres_reg <= metres_next;
        end
    end

    assign metres = metres_reg;

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (metres <= MAX_METRES))
        else $error("distance above antipodal limit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(metres)))
        else $error("stalled result changed");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> $stable(vld_reg))
        else $error("pipeline advanced under stall");

endmodule

// ===== design/hdc_rot_cell.sv =====
// One rotation-mode CORDIC iteration with its output register.
module hdc_rot_cell (
    input  logic             clk,
    input  logic             en,
    input  logic [4:0]       step,
    input  hdc_pkg::xyz_t    d_in,
    output hdc_pkg::xyz_t    d_out
);

    hdc_pkg::xyz_t d_reg;
    hdc_pkg::xyz_t d_next;
    logic signed [hdc_pkg::AW-1:0] x;
    logic signed [hdc_pkg::AW-1:0] y;
    logic signed [hdc_pkg::AW-1:0] dx;
    logic signed [hdc_pkg::AW-1:0] dy;
    logic signed [hdc_pkg::AW-1:0] at;

    always_comb
    begin
        x  = d_in.x;
        y  = d_in.y;
        dx = y >>> step;
        dy = x >>> step;
        at = signed'({2'b00, hdc_pkg::ATAN_TAB[step]});
        if (!d_in.z[hdc_pkg::AW-1])
        begin
            d_next.x = x - dx;
            d_next.y = y + dy;
            d_next.z = d_in.z - at;
        end
        else
        begin
            d_next.x = x + dx;
            d_next.y = y - dy;
            d_next.z = d_in.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== design/hdc_vec_cell.sv =====
// One vectoring-mode CORDIC iteration with its output register.
module hdc_vec_cell (
    input  logic             clk,
    input  logic             en,
    input  logic [4:0]       step,
    input  hdc_pkg::xyz_t    d_in,
    output hdc_pkg::xyz_t    d_out
);

    hdc_pkg::xyz_t d_reg;
    hdc_pkg::xyz_t d_next;
    logic signed [hdc_pkg::AW-1:0] x;
    logic signed [hdc_pkg::AW-1:0] y;
    logic signed [hdc_pkg::AW-1:0] dx;
    logic signed [hdc_pkg::AW-1:0] dy;
    logic signed [hdc_pkg::AW-1:0] at;

    always_comb
    begin
        x  = d_in.x;
        y  = d_in.y;
        dx = y >>> step;
        dy = x >>> step;
        at = signed'({2'b00, hdc_pkg::ATAN_TAB[step]});
        if (!y[hdc_pkg::AW-1] && (|y))
        begin
            d_next.x = x + dx;
            d_next.y = y - dy;
            d_next.z = d_in.z + at;
        end
        else
        begin
            d_next.x = x - dx;
            d_next.y = y + dy;
            d_next.z = d_in.z - at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== design/hdc_sqrt_cell.sv =====
// One digit step of the exact integer square root, registered.
module hdc_sqrt_cell (
    input  logic             clk,
    input  logic             en,
    input  logic [4:0]       step,
    input  hdc_pkg::sqrt_t   d_in,
    output hdc_pkg::sqrt_t   d_out
);

    hdc_pkg::sqrt_t d_reg;
    hdc_pkg::sqrt_t d_next;
    logic [5:0]  sh;
    logic [63:0] bitv;
    logic [63:0] trial;

    always_comb
    begin
        sh    = 6'd62 - {step, 1'b0};
        bitv  = 64'd1 << sh;
        trial = d_in.res + bitv;
        if (d_in.n >= trial)
        begin
            d_next.n   = d_in.n - trial;
            d_next.res = (d_in.res >> 1) + bitv;
        end
        else
        begin
            d_next.n   = d_in.n;
            d_next.res = d_in.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== tb/sv/haversine_distance_top_tb.sv =====
// Self-checking testbench for the haversine distance pipeline.
module haversine_distance_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FULL_UDEG    = 360000000;
    localparam longint HALF_UDEG    = 180000000;
    localparam longint QUARTER_UDEG = 90000000;
    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam longint ONE_Q30      = 64'sd1 << 30;
    localparam longint HALF_PI_Q30  = 64'h6487ED51;
    localparam longint GAIN_Q30     = 64'h26DD3B6A;
    localparam longint EARTH_MM     = 6367000;
    localparam longint MAX_METRES   = 20002432;
    localparam int     LATENCY      = 42 + 2 * hdc_pkg::CORDIC_STEPS;
    localparam int     WATCHDOG     = 20000;
    localparam int     N_RANDOM     = 1430;

    typedef struct {
        logic signed [28:0] lon_a;
        logic signed [27:0] lat_a;
        logic signed [28:0] lon_b;
        logic signed [27:0] lat_b;
    } point_pair_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic signed [28:0] lon_a;
    logic signed [27:0] lat_a;
    logic signed [28:0] lon_b;
    logic signed [27:0] lat_b;
    logic               rsp_valid;
    logic               rsp_stall;
    logic [24:0]        metres;

    haversine_distance_top dut (.*);

    point_pair_t pending_reqs[$];
    logic [24:0] expected_metres[$];
    int          error_count;
    int          idle_cycles;
    int          results_seen;
    int          hold_off;       // receiver hold-off, cycles left
    bit          send_pause;     // sender waits for the pipe to drain
    bit          no_idle;        // stretch with no random idling
    bit          stim_done;
    bit          req_taken;      // request on the pins was accepted at the last edge

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint udeg_to_rad(longint udeg, int sh);
        logic [63:0] rad_per_udeg;
        logic [63:0] p;
        rad_per_udeg = PI_Q60 / 64'd180000000;
        p = udeg * rad_per_udeg;
        return longint'(p >> sh);
    endfunction

    function automatic longint fold_angle(longint d);
        longint r;
        r = d % FULL_UDEG;
        if (r < 0)
            r += FULL_UDEG;
        if (r > HALF_UDEG)
            r = FULL_UDEG - r;
        return r;
    endfunction

    function automatic void cordic_sincos(input longint ang, output longint s,
                                          output longint c);
        longint x, y, z, dx, dy;
        x = GAIN_Q30;
        y = 0;
        z = ang;
        for (int i = 0; i < hdc_pkg::CORDIC_STEPS && i < 32; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(hdc_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(hdc_pkg::ATAN_TAB[i]);
            end
        end
        s = clip(y, 0, ONE_Q30);
        c = clip(x, 0, ONE_Q30);
    endfunction

    function automatic longint cordic_atan2(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < hdc_pkg::CORDIC_STEPS && i < 32; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(hdc_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(hdc_pkg::ATAN_TAB[i]);
            end
        end
        return clip(z, 0, HALF_PI_Q30);
    endfunction

    function automatic longint int_sqrt_q30(longint v);
        logic [63:0] n, res, b;
        n = 64'(v) << 30;
        res = 0;
        b = 64'd1 << 62;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint lat_cosine(longint lat);
        longint m, s, c;
        bit neg;
        m = lat < 0 ? -lat : lat;
        neg = 1'b0;
        if (m > HALF_UDEG)
            m = HALF_UDEG;
        if (m > QUARTER_UDEG)
        begin
            m = HALF_UDEG - m;
            neg = 1'b1;
        end
        cordic_sincos(udeg_to_rad(m, 30), s, c);
        return neg ? -c : c;
    endfunction

    function automatic longint half_angle_sin_sq(longint d);
        longint s, c;
        cordic_sincos(udeg_to_rad(fold_angle(d), 31), s, c);
        return (s * s) >>> 30;
    endfunction

    function automatic logic [24:0] great_circle_metres(point_pair_t p);
        longint s_lat, s_lon, cc, a, z, m;
        s_lat = half_angle_sin_sq(longint'(p.lat_b) - longint'(p.lat_a));
        s_lon = half_angle_sin_sq(longint'(p.lon_b) - longint'(p.lon_a));
        cc = floor_shr(lat_cosine(p.lat_a) * lat_cosine(p.lat_b), 30);
        a = clip(s_lat + floor_shr(cc * s_lon, 30), 0, ONE_Q30);
        z = cordic_atan2(int_sqrt_q30(a), int_sqrt_q30(ONE_Q30 - a));
        m = (2 * z * EARTH_MM + (64'sd1 << 29)) >>> 30;
        if (m > MAX_METRES)
            m = MAX_METRES;
        return m[24:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic add_pair(longint la, longint pa, longint lb, longint pb);
        point_pair_t p;
        p.lon_a = 29'(la); p.lat_a = 28'(pa); p.lon_b = 29'(lb); p.lat_b = 28'(pb);
        pending_reqs.insert(pending_reqs.size(), p);
    endtask

    function automatic longint rand_field(int w, bit in_range, longint lim);
        logic [31:0] r;
        if (in_range)
            return longint'($urandom_range(32'(2 * lim))) - lim;
        r = $urandom();
        return longint'(signed'(r[27:0])) * (w == 29 ? 2 : 1) + (w == 29 ? r[28] : 0);
    endfunction

    // driver: a request stays on the pins until it is accepted
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_taken)
        begin
            if (pending_reqs.size() > 0 && !send_pause &&
                (no_idle || $urandom_range(99) >= 34))
            begin
                req_valid <= 1'b1;
                lon_a <= pending_reqs[0].lon_a;
                lat_a <= pending_reqs[0].lat_a;
                lon_b <= pending_reqs[0].lon_b;
                lat_b <= pending_reqs[0].lat_b;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_off > 0)
        begin
            rsp_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
            rsp_stall <= !no_idle && $urandom_range(99) < 34;
    end

    // prediction on accepted requests, checking on accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken = req_valid && !req_stall;
            if (req_taken)
            begin
                point_pair_t p;
                p.lon_a = lon_a; p.lat_a = lat_a; p.lon_b = lon_b; p.lat_b = lat_b;
                expected_metres.insert(expected_metres.size(), great_circle_metres(p));
                void'(pending_reqs.pop_front());
            end
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (expected_metres.size() == 0)
                    report_mismatch("unexpected result, metres", metres, -1);
                else if (metres !== expected_metres[0])
                    report_mismatch("metres", metres, expected_metres.pop_front());
                else
                    void'(expected_metres.pop_front());
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("timeout waiting for handshakes");
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        longint la, pa, lb, pb;
        bit ok;
        rst_n = 1'b0;
        req_valid = 1'b0;
        rsp_stall = 1'b0;
        lon_a = 0; lat_a = 0; lon_b = 0; lat_b = 0;
        error_count = 0; idle_cycles = 0; results_seen = 0;
        hold_off = 0; send_pause = 0; no_idle = 0; stim_done = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, antipodes, coincident points, wrap, out-of-range
        add_pair(0, 0, 0, 0);
        add_pair(0, 0, 180000000, 0);
        add_pair(-180000000, 0, 180000000, 0);
        add_pair(0, 90000000, 0, -90000000);
        add_pair(0, 90000000, 0, 90000000);
        add_pair(-180000000, -90000000, 180000000, 90000000);
        add_pair(10000000, 45000000, -170000000, -45000000);
        add_pair(179999999, 0, -179999999, 0);
        add_pair(0, 0, 0, 1);
        add_pair(0, 0, 1, 0);
        add_pair(-268435456, -134217728, 268435455, 134217727);
        add_pair(268435455, 134217727, -268435456, -134217728);
        add_pair(0, 134217727, 0, 0);
        add_pair(0, -100000000, 90000000, 100000000);
        add_pair(268435455, 0, -268435456, 0);
        add_pair(123456789, 12345678, -98765432, -87654321);
        add_pair(-1, -1, 0, 0);
        add_pair(90000000, 0, -90000000, 0);
        add_pair(0, 89999999, 180000000, 89999999);
        add_pair(0, 45000000, 0, 45000001);
        wait (pending_reqs.size() == 0);
        send_pause = 1;
        wait (expected_metres.size() == 0);
        @(negedge clk);
        send_pause = 0;

        // random: mostly in range, some raw field values
        for (int i = 0; i < N_RANDOM; i++)
        begin
            ok = $urandom_range(99) < 85;
            la = rand_field(29, ok, 180000000);
            pa = rand_field(28, ok, 90000000);
            lb = rand_field(29, ok, 180000000);
            pb = rand_field(28, ok, 90000000);
            if ($urandom_range(9) == 0)
            begin
                lb = la + longint'($urandom_range(2000)) - 1000;
                pb = pa + longint'($urandom_range(2000)) - 1000;
            end
            add_pair(la, pa, lb, pb);
            if (i == 300)
            begin
                wait (pending_reqs.size() < 10);
                hold_off = 400;
            end
            if (i == 700)
            begin
                wait (pending_reqs.size() == 0);
                send_pause = 1;
                wait (expected_metres.size() == 0);
                @(negedge clk);
                send_pause = 0;
            end
            if (i == 900)
                no_idle = 1;
            if (i == 1150)
            begin
                wait (pending_reqs.size() == 0);
                no_idle = 0;
            end
        end
        wait (pending_reqs.size() == 0);
        wait (expected_metres.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d point pairs covering range extremes, wraparound and raw field values;",
                 20 + N_RANDOM);
        $display("%0d distances checked under random and long stalls on both channels.",
                 results_seen);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/hdc_pkg.sv
design/hdc_rot_cell.sv
design/hdc_vec_cell.sv
design/hdc_sqrt_cell.sv
design/haversine_distance_top.sv
tb/sv/haversine_distance_top_tb.sv
